// ----- rtl/gpe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_pkg
// Constants, register codes and the exponential table of the gaussian core.
// ----------------------------------------------------------------------------
package gpe_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int EXP_DEPTH_LOG2  = 8;
	localparam int EXP_DEPTH       = 1 << EXP_DEPTH_LOG2;
	localparam int EXP_RANGE_LOG2  = 5;
	localparam int RATIO_LOG2      = 3;
	localparam int T_W             = FRAC_BITS + EXP_RANGE_LOG2;
	localparam int TIDX            = T_W - EXP_DEPTH_LOG2;
	localparam int Q_W             = FRAC_BITS + RATIO_LOG2;
	localparam int SQ_W            = 2 * Q_W;
	localparam int E_W             = 31;
	localparam int TAYLOR_TERMS    = 24;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd2;

	localparam logic [31:0] AMPLITUDE_RST = 32'(1) << FRAC_BITS;
	localparam logic [31:0] CENTER_RST    = 32'd0;
	localparam logic [30:0] WIDTH_RST     = 31'(1) << FRAC_BITS;

	typedef logic [E_W-1:0] exp_tab_t [0:EXP_DEPTH];

	function automatic exp_tab_t build_exp_table();
		exp_tab_t    tab;
		logic [63:0] delta;
		logic [63:0] term;
		logic [63:0] m;
		longint      sum;
		delta = ((64'(1 << EXP_RANGE_LOG2) << 30) + 64'(EXP_DEPTH / 2)) / 64'(EXP_DEPTH);
		term  = 64'(1) << 30;
		sum   = longint'(64'(1) << 30);
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			term = ((term * delta) >> 30) / 64'(n);
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		m = (sum > 0) ? 64'(sum) : 64'd0;
		term = 64'(1) << 30;
		tab[0] = E_W'(term);
		for (int j = 1; j <= EXP_DEPTH; j++) begin
			term = (term * m + (64'(1) << 29)) >> 30;
			tab[j] = E_W'(term);
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_table();

endpackage

// ----- rtl/gpe_sample_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_sample_if
// Input channel: one abscissa word with its last flag.
// ----------------------------------------------------------------------------
interface gpe_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample;
	logic               last_sample;

	modport source (output valid, sample, last_sample, input ready);
	modport sink   (input valid, sample, last_sample, output ready);
endinterface

// ----- rtl/gpe_value_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_value_if
// Output channel: one gaussian value word with its last flag.
// ----------------------------------------------------------------------------
interface gpe_value_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               last_value;

	modport source (output valid, value, last_value, input ready);
	modport sink   (input valid, value, last_value, output ready);
endinterface

// ----- rtl/gpe_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_div
// Pipelined restoring divider, one quotient bit per stage: r = (d << F) / s.
// ----------------------------------------------------------------------------
module gpe_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_v,
	input  logic [32:0]             d,
	input  logic                    in_uf,
	input  logic                    in_last,
	input  logic [30:0]             divisor,
	output logic                    out_v,
	output logic [gpe_pkg::Q_W-1:0] quot,
	output logic                    out_uf,
	output logic                    out_last
);
	import gpe_pkg::*;

	logic [30:0]    rem_s  [0:Q_W];
	logic [Q_W-1:0] lo_s   [0:Q_W];
	logic [Q_W-1:0] q_s    [0:Q_W];
	logic           v_s    [0:Q_W];
	logic           uf_s   [0:Q_W];
	logic           last_s [0:Q_W];

	logic [FRAC_BITS+33-1:0] dn;

	assign dn = {d, {FRAC_BITS{1'b0}}};

	assign rem_s[0]  = 31'(dn >> Q_W);
	assign lo_s[0]   = dn[Q_W-1:0];
	assign q_s[0]    = '0;
	assign v_s[0]    = in_v;
	assign uf_s[0]   = in_uf;
	assign last_s[0] = in_last;

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [31:0] tr;
		logic        ge;

		assign tr = {rem_s[k], lo_s[k][Q_W-1]};
		assign ge = tr >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1]  <= ge ? 31'(tr - {1'b0, divisor}) : tr[30:0];
				lo_s[k+1]   <= lo_s[k] << 1;
				q_s[k+1]    <= {q_s[k][Q_W-2:0], ge};
				uf_s[k+1]   <= uf_s[k];
				last_s[k+1] <= last_s[k];
			end
		end
	end

	assign out_v    = v_s[Q_W];
	assign quot     = q_s[Q_W];
	assign out_uf   = uf_s[Q_W];
	assign out_last = last_s[Q_W];
endmodule

// ----- rtl/gpe_exp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_exp
// exp(-r^2/2) in Q30: square, table lookup, interpolation; four stages.
// ----------------------------------------------------------------------------
module gpe_exp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_v,
	input  logic [gpe_pkg::Q_W-1:0] ratio,
	input  logic                    in_uf,
	input  logic                    in_last,
	output logic                    out_v,
	output logic [gpe_pkg::E_W-1:0] e,
	output logic                    out_last
);
	import gpe_pkg::*;

	logic [SQ_W-1:0]         sq_s1;
	logic [E_W-1:0]          a_s2, dab_s2;
	logic [T_W-1:0]          f_s2;
	logic [E_W-1:0]          a_s3;
	logic [E_W+T_W-1:0]      prod_s3;
	logic [E_W-1:0]          e_s4;
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    uf_s1, uf_s2, uf_s3;
	logic                    last_s1, last_s2, last_s3, last_s4;

	logic [T_W-1:0]            t;
	logic [EXP_DEPTH_LOG2-1:0] j;
	logic [EXP_DEPTH_LOG2:0]   j1;
	logic [E_W-1:0]            ta, tb;

	assign t  = T_W'(sq_s1 >> (FRAC_BITS + 1));
	assign j  = t[T_W-1:TIDX];
	assign j1 = {1'b0, j} + 1'b1;
	assign ta = EXP_TAB[j];
	assign tb = EXP_TAB[j1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s1   <= ratio * ratio;
			uf_s1   <= in_uf;
			last_s1 <= in_last;

			a_s2    <= ta;
			dab_s2  <= ta - tb;
			f_s2    <= T_W'({t[TIDX-1:0], {EXP_DEPTH_LOG2{1'b0}}});
			uf_s2   <= uf_s1;
			last_s2 <= last_s1;

			a_s3    <= a_s2;
			prod_s3 <= dab_s2 * f_s2;
			uf_s3   <= uf_s2;
			last_s3 <= last_s2;

			e_s4    <= uf_s3 ? '0 : a_s3 - E_W'(prod_s3 >> T_W);
			last_s4 <= last_s3;
		end
	end

	assign out_v    = v_s4;
	assign e        = e_s4;
	assign out_last = last_s4;
endmodule

// ----- rtl/gaussian_profile_eval_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_profile_eval_core
// value = amplitude * exp(-(x - center)^2 / (2 * width^2)), signed Q16.16.
//
//   port     dir  word                         handshake
//   samples  in   sample, last_sample          valid/ready
//   values   out  value, last_value            valid/ready
//   cfg_*    in   index, data (32 bits)        write enable, no back-pressure
//
// One word per cycle unless stalled: input regs, divider, exp, output regs.
// The divider pipeline, one quotient bit per stage, sets the depth.
// Reset clears valid bits and loads register defaults.
// A stall on values freezes every stage; samples.ready follows it.
// ----------------------------------------------------------------------------
module gaussian_profile_eval_core (
	input  logic                             clk,
	input  logic                             arst_n,
	gpe_sample_if.sink                       samples,
	gpe_value_if.source                      values,
	input  logic                             cfg_we,
	input  logic [gpe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                      cfg_data
);
	import gpe_pkg::*;

	logic [31:0] amp_q, center_q;
	logic [30:0] width_q;
	logic [30:0] s_eff;
	logic        adv;

	logic signed [32:0] diff_s1;
	logic               v_s1, last_s1;
	logic [32:0]        d_s2;
	logic               v_s2, uf_s2, last_s2;

	logic           dv_v, dv_uf, dv_last;
	logic [Q_W-1:0] dv_q;
	logic           ex_v, ex_last;
	logic [E_W-1:0] ex_e;

	logic [31:0]        mag;
	logic [E_W+31:0]    p_m1;
	logic               neg_m1, v_m1, last_m1;
	logic [33:0]        pr;
	logic [31:0]        val;
	logic [31:0]        val_m2;
	logic               v_m2, last_m2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q    <= AMPLITUDE_RST;
			center_q <= CENTER_RST;
			width_q  <= WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AMPLITUDE: amp_q    <= cfg_data;
				REG_CENTER:    center_q <= cfg_data;
				REG_WIDTH:     width_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	assign s_eff = (width_q == '0) ? 31'd1 : width_q;
	assign adv   = !v_m2 || values.ready;
	assign samples.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= samples.valid;
			v_s2 <= v_s1;
			v_m1 <= ex_v;
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s1 <= 33'(samples.sample) - 33'($signed(center_q));
			last_s1 <= samples.last_sample;
			d_s2    <= diff_s1[32] ? 33'(-diff_s1) : 33'(diff_s1);
			uf_s2   <= {1'b0, (diff_s1[32] ? 33'(-diff_s1) : 33'(diff_s1))}
				>= {s_eff, {RATIO_LOG2{1'b0}}};
			last_s2 <= last_s1;
		end
	end

	gpe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s2),
		.d        (d_s2),
		.in_uf    (uf_s2),
		.in_last  (last_s2),
		.divisor  (s_eff),
		.out_v    (dv_v),
		.quot     (dv_q),
		.out_uf   (dv_uf),
		.out_last (dv_last)
	);

	gpe_exp u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (dv_v),
		.ratio    (dv_q),
		.in_uf    (dv_uf),
		.in_last  (dv_last),
		.out_v    (ex_v),
		.e        (ex_e),
		.out_last (ex_last)
	);

	assign mag = amp_q[31] ? 32'(-amp_q) : amp_q;
	assign pr  = 34'((p_m1 + (E_W+32)'(64'(1) << 29)) >> 30);

	always_comb begin
		if (neg_m1) begin
			val = (pr > 34'h0_8000_0000) ? 32'h8000_0000 : 32'(-pr[31:0]);
		end else begin
			val = (pr > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : pr[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_m1    <= mag * ex_e;
			neg_m1  <= amp_q[31];
			last_m1 <= ex_last;
			val_m2  <= val;
			last_m2 <= last_m1;
		end
	end

	assign values.valid      = v_m2;
	assign values.value      = val_m2;
	assign values.last_value = last_m2;
endmodule
